### sv/context_sample_table_matcher_defines.svh
// Assertion macros for the context sample table matcher.
// Included by the top level; no other dependencies.
`ifndef CONTEXT_SAMPLE_TABLE_MATCHER_DEFINES_SVH
`define CONTEXT_SAMPLE_TABLE_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define CSTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check a property on every clock edge, reset included
`define CSTM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CSTM_ASSERT(lbl, prop, msg)
`define CSTM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/cstm_pkg.sv
// Shared types and codes of the context sample table matcher.
// No dependencies; used by cstm_cell and the top level.
`timescale 1ns / 1ps
package cstm_pkg;

  localparam int unsigned SLOT_W = 4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_AMBIG    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_STALE    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_INVALID  = 3'd5,
    ST_REJECT   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_FRESH  = 2'd1,
    MODE_ANY    = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_PROCESS_BASE   = 3'd0,
    REG_PROCESS_LENGTH = 3'd1,
    REG_SYSTEM_BASE    = 3'd2,
    REG_SYSTEM_LENGTH  = 3'd3,
    REG_AGE_LIMIT      = 3'd4
  } cfg_reg_e;

  // fixed-width part of one table entry
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] stack;
    logic [31:0] window;
    logic [31:0] menu;
    logic [31:0] tstamp;
  } ent_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic ambig;
    logic hit;
    logic mism;
    logic stale;
    logic khit;
    logic efound;
    ent_t found;
  } tok_t;

  // query held steady during a scan
  typedef struct packed {
    ent_t        item;
    logic        fresh;
    logic [7:0]  len;
    logic [31:0] pbase;
    logic [31:0] ahi;
    logic [31:0] sbase;
    logic [31:0] shi;
    logic [31:0] age_limit;
  } query_t;

endpackage

### sv/context_sample_table_matcher.sv
// Top level of the context sample table matcher: control, registers, cell chain.
// Depends on cstm_pkg, cstm_cell and context_sample_table_matcher_defines.svh.
`timescale 1ns / 1ps
`include "context_sample_table_matcher_defines.svh"
// The table lives in a chain of ENTRIES cells, one entry per cell. Each item
// sends a scan token down the chain, one cell per cycle, and the token
// collects the match verdict and, for a record, the slot to write. One item
// is in flight at a time: the next transfer waits for the launch register,
// the token walk through the chain, the capture register and the result,
// which waits while a held result stalls. A record write lands at the
// result cycle. The result register holds the answer until it is taken, and
// the next item may be accepted while it waits.
module context_sample_table_matcher import cstm_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned LABEL_SIZE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] context_key_i,
  input  logic [31:0] stack_addr_i,
  input  logic [31:0] window_addr_i,
  input  logic [31:0] menu_addr_i,
  input  logic [31:0] time_value_i,
  input  logic [7:0]  label_length_i,
  input  logic [63:0] label_bytes_a_i,
  input  logic [63:0] label_bytes_b_i,
  input  logic [63:0] label_bytes_c_i,
  input  logic [63:0] label_bytes_d_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_index_o,
  output logic [31:0] found_key_o,
  output logic [31:0] found_stack_o,
  output logic [31:0] found_window_o,
  output logic [31:0] found_menu_o,
  output logic [31:0] found_time_o
);

  localparam int unsigned IW     = $clog2(ENTRIES);
  localparam int unsigned NB     = LABEL_SIZE - 1;
  localparam int unsigned NAME_W = 8 * NB;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [31:0] pbase_q, plen_q, sbase_q, slen_q, age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pbase_q <= 32'd0;
      plen_q  <= 32'd0;
      sbase_q <= 32'd0;
      slen_q  <= 32'd0;
      age_q   <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_PROCESS_BASE:   pbase_q <= cfg_wdata_i;
        REG_PROCESS_LENGTH: plen_q  <= cfg_wdata_i;
        REG_SYSTEM_BASE:    sbase_q <= cfg_wdata_i;
        REG_SYSTEM_LENGTH:  slen_q  <= cfg_wdata_i;
        REG_AGE_LIMIT:      age_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic in_xfer, out_xfer, fire;
  assign in_stall_o = state_q != S_IDLE;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign fire       = state_q == S_DONE && (!out_valid_o || !out_stall_i);

  // truncate and zero-pad the incoming name
  logic [255:0]      raw_name;
  logic [7:0]        len_trunc;
  logic [NAME_W-1:0] name_masked;
  logic [32:0]       padd, sadd;

  always_comb begin
    raw_name  = {label_bytes_d_i, label_bytes_c_i, label_bytes_b_i, label_bytes_a_i};
    len_trunc = (label_length_i >= 8'(LABEL_SIZE)) ? 8'(LABEL_SIZE - 1) : label_length_i;
    for (int b = 0; b < NB; b++) begin
      name_masked[8*b +: 8] = (8'(b) < len_trunc) ? raw_name[8*b +: 8] : 8'd0;
    end
    padd = {1'b0, pbase_q} + {1'b0, plen_q};
    sadd = {1'b0, sbase_q} + {1'b0, slen_q};
  end

  // hold the query for the whole scan
  query_t            query_q;
  mode_e             mode_q;
  logic [7:0]        rec_len_q;
  logic [NAME_W-1:0] qname_q;
  logic              part_bad_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      query_q.item.key    <= context_key_i;
      query_q.item.stack  <= stack_addr_i;
      query_q.item.window <= window_addr_i;
      query_q.item.menu   <= menu_addr_i;
      query_q.item.tstamp <= time_value_i;
      query_q.fresh       <= mode_e'(mode_i) == MODE_FRESH;
      query_q.len         <= label_length_i;
      query_q.pbase       <= pbase_q;
      query_q.ahi         <= padd[31:0];
      query_q.sbase       <= sbase_q;
      query_q.shi         <= sadd[31:0];
      query_q.age_limit   <= age_q;
      mode_q              <= mode_e'(mode_i);
      rec_len_q           <= len_trunc;
      qname_q             <= name_masked;
      part_bad_q          <= plen_q == 32'd0 || slen_q == 32'd0 || padd[32] || sadd[32];
    end
  end

  // launch the token into the first cell
  logic launch_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= 1'b0;
    end else begin
      launch_q <= in_xfer;
    end
  end

  tok_t          tok_w   [ENTRIES+1];
  logic [IW-1:0] hidx_w  [ENTRIES+1];
  logic [IW-1:0] kidx_w  [ENTRIES+1];
  logic [IW-1:0] eidx_w  [ENTRIES+1];
  logic [ENTRIES-1:0] tok_vld;

  logic          wr_en;
  logic [IW-1:0] wr_idx;

  always_comb begin
    tok_w[0]       = '0;
    tok_w[0].valid = launch_q;
    hidx_w[0]      = '0;
    kidx_w[0]      = '0;
    eidx_w[0]      = '0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    cstm_cell #(
      .IW(IW), .NAME_W(NAME_W), .IDX(g), .LABEL_SIZE(LABEL_SIZE)
    ) u_cell (
      .clk_i, .rst_ni,
      .query_i     (query_q),
      .qname_i     (qname_q),
      .tok_i       (tok_w[g]),
      .hit_idx_i   (hidx_w[g]),
      .key_idx_i   (kidx_w[g]),
      .empty_idx_i (eidx_w[g]),
      .tok_o       (tok_w[g+1]),
      .hit_idx_o   (hidx_w[g+1]),
      .key_idx_o   (kidx_w[g+1]),
      .empty_idx_o (eidx_w[g+1]),
      .wr_en_i     (wr_en),
      .wr_idx_i    (wr_idx),
      .wr_ent_i    (query_q.item),
      .wr_len_i    (rec_len_q),
      .wr_name_i   (qname_q)
    );
    assign tok_vld[g] = tok_w[g+1].valid;
  end

  // capture the token leaving the chain
  tok_t          fin_q;
  logic [IW-1:0] fin_hidx_q, fin_kidx_q, fin_eidx_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && tok_w[ENTRIES].valid) begin
      fin_q      <= tok_w[ENTRIES];
      fin_hidx_q <= hidx_w[ENTRIES];
      fin_kidx_q <= kidx_w[ENTRIES];
      fin_eidx_q <= eidx_w[ENTRIES];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_SCAN;
      S_SCAN:  if (tok_w[ENTRIES].valid) state_d = S_DONE;
      S_DONE:  if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // form the result and the record write
  logic [IW-1:0] rptr_q, rptr_d;
  status_e       res_status;
  logic [IW-1:0] res_slot;
  ent_t          res_ent;
  logic          use_rptr;

  always_comb begin
    res_status = ST_INVALID;
    res_slot   = '0;
    res_ent    = '0;
    use_rptr   = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = '0;
    case (mode_q)
      MODE_RECORD: begin
        if (query_q.item.key == 32'd0) begin
          res_status = ST_REJECT;
        end else begin
          res_status = ST_OK;
          wr_en      = fire;
          if (fin_q.khit) begin
            wr_idx = fin_kidx_q;
          end else if (fin_q.efound) begin
            wr_idx = fin_eidx_q;
          end else begin
            wr_idx   = rptr_q;
            use_rptr = 1'b1;
          end
          res_slot = wr_idx;
        end
      end
      MODE_FRESH, MODE_ANY: begin
        if (part_bad_q) begin
          res_status = ST_INVALID;
        end else if (fin_q.ambig) begin
          res_status = ST_AMBIG;
        end else if (fin_q.hit) begin
          res_status = ST_OK;
          res_slot   = fin_hidx_q;
          res_ent    = fin_q.found;
        end else if (fin_q.mism) begin
          res_status = ST_MISMATCH;
        end else if (fin_q.stale) begin
          res_status = ST_STALE;
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      default: res_status = ST_INVALID;
    endcase
    rptr_d = rptr_q;
    if (fire && use_rptr) begin
      rptr_d = (rptr_q == LAST_IDX) ? '0 : rptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q <= '0;
    end else begin
      rptr_q <= rptr_d;
    end
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_o       <= res_status;
      slot_index_o   <= SLOT_W'(res_slot);
      found_key_o    <= res_ent.key;
      found_stack_o  <= res_ent.stack;
      found_window_o <= res_ent.window;
      found_menu_o   <= res_ent.menu;
      found_time_o   <= res_ent.tstamp;
    end
  end

  assign out_valid_o = out_valid_q;

  `CSTM_ASSERT(a_xfer_idle, in_xfer |=> state_q == S_SCAN && launch_q, "transfer outside idle")
  `CSTM_ASSERT(a_one_token, $onehot0(tok_vld), "more than one token in chain")
  `CSTM_ASSERT(a_tail_scan, tok_w[ENTRIES].valid |-> state_q == S_SCAN, "token exits outside scan")
  `CSTM_ASSERT(a_fields_zero, out_valid_o && status_o != ST_OK |-> found_key_o == 32'd0, "found fields set on failed result")

endmodule

### sv/cstm_cell.sv
// One table entry plus one stage of the scan chain.
// Depends on cstm_pkg.
`timescale 1ns / 1ps
module cstm_cell import cstm_pkg::*; #(
  parameter int unsigned IW     = 4,
  parameter int unsigned NAME_W = 248,
  parameter int unsigned IDX    = 0,
  parameter int unsigned LABEL_SIZE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  query_t            query_i,
  input  logic [NAME_W-1:0] qname_i,
  input  tok_t              tok_i,
  input  logic [IW-1:0]     hit_idx_i,
  input  logic [IW-1:0]     key_idx_i,
  input  logic [IW-1:0]     empty_idx_i,
  output tok_t              tok_o,
  output logic [IW-1:0]     hit_idx_o,
  output logic [IW-1:0]     key_idx_o,
  output logic [IW-1:0]     empty_idx_o,
  input  logic              wr_en_i,
  input  logic [IW-1:0]     wr_idx_i,
  input  ent_t              wr_ent_i,
  input  logic [7:0]        wr_len_i,
  input  logic [NAME_W-1:0] wr_name_i
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [31:0]       key_q;
  ent_t              ent_q;
  logic [7:0]        len_q;
  logic [NAME_W-1:0] name_q;

  tok_t          tok_d, tok_q;
  logic [IW-1:0] hit_idx_d, hit_idx_q, key_idx_d, key_idx_q, empty_idx_d, empty_idx_q;

  logic occ, pass, name_ok, too_old;
  logic key_in, stk_in, win_ok, menu_ok;
  logic [31:0] age;

  // entry filter against both partitions
  always_comb begin
    occ     = key_q != 32'd0;
    key_in  = key_q >= query_i.pbase && key_q < query_i.ahi;
    stk_in  = ent_q.stack >= query_i.pbase && ent_q.stack < query_i.ahi;
    win_ok  = ent_q.window == 32'd0 ||
              (ent_q.window >= query_i.pbase && ent_q.window < query_i.ahi) ||
              (ent_q.window >= query_i.sbase && ent_q.window < query_i.shi);
    menu_ok = ent_q.menu == 32'd0 ||
              (ent_q.menu >= query_i.pbase && ent_q.menu < query_i.ahi) ||
              (ent_q.menu >= query_i.sbase && ent_q.menu < query_i.shi);
    pass    = occ && key_in && ent_q.stack != 32'd0 && stk_in && win_ok && menu_ok;
    name_ok = query_i.len < 8'(LABEL_SIZE) && len_q == query_i.len && name_q == qname_i;
    age     = query_i.item.tstamp - ent_q.tstamp;
    too_old = query_i.fresh && age > query_i.age_limit;
  end

  // fold this entry into the passing token
  always_comb begin
    tok_d       = tok_i;
    hit_idx_d   = hit_idx_i;
    key_idx_d   = key_idx_i;
    empty_idx_d = empty_idx_i;
    if (tok_i.valid) begin
      if (!tok_i.ambig && pass) begin
        if (!name_ok) begin
          tok_d.mism = 1'b1;
        end else if (too_old) begin
          tok_d.stale = 1'b1;
        end else if (tok_i.hit) begin
          tok_d.ambig = 1'b1;
        end else begin
          tok_d.hit     = 1'b1;
          tok_d.found   = ent_q;
          tok_d.found.key = key_q;
          hit_idx_d     = MY_IDX;
        end
      end
      if (occ && key_q == query_i.item.key && !tok_i.khit) begin
        tok_d.khit = 1'b1;
        key_idx_d  = MY_IDX;
      end
      if (!occ && !tok_i.efound) begin
        tok_d.efound = 1'b1;
        empty_idx_d  = MY_IDX;
      end
    end
  end

  // advance the token one cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    key_idx_q   <= key_idx_d;
    empty_idx_q <= empty_idx_d;
  end

  // key marks the entry occupied
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= 32'd0;
    end else if (wr_en_i && wr_idx_i == MY_IDX) begin
      key_q <= wr_ent_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_idx_i == MY_IDX) begin
      ent_q  <= wr_ent_i;
      len_q  <= wr_len_i;
      name_q <= wr_name_i;
    end
  end

  assign tok_o       = tok_q;
  assign hit_idx_o   = hit_idx_q;
  assign key_idx_o   = key_idx_q;
  assign empty_idx_o = empty_idx_q;

endmodule
